// File: hw/rtl/scd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// scd_pkg: shared types and constants
// Types and fixed constants for the signature and checksum deframer.
// ============================================================================
package scd_pkg;

    localparam int BYTE_W     = 8;
    localparam int SIG_W      = 64;
    localparam int SIG_BYTES  = SIG_W / BYTE_W;
    localparam int SIG_IDX_W  = $clog2(SIG_BYTES);
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam int USER_W     = 2;

    // Register index, taken from byte address bit 3 (registers are 8 bytes apart).
    localparam logic REG_SIGNATURE = 1'b0;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DRAIN,
        ST_STATUS
    } t_state;

    typedef struct packed {
        logic take_byte;    // accept a non-final word into the frame state
        logic take_final;   // accept the checksum word and settle the frame
        logic load_data;    // move the next payload byte into the output register
        logic load_status;  // move a status-only result into the output register
    } t_cmd;

    typedef struct packed {
        logic final_ok;     // frame would pass if the current word is the final one
        logic has_payload;  // frame would release at least one payload byte
        logic last_read;    // read pointer stands on the last payload byte
        logic out_free;     // output register can take a result this cycle
    } t_stat;

endpackage

// File: hw/rtl/scd_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// scd_ctrl: deframer controller
// Collects frame words, then either drains the payload or sends one status
// result, sequencing the datapath through command signals.
// ============================================================================
module scd_ctrl
    import scd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_last) begin
                        o_cmd.take_final = 1'b1;
                        if (i_stat.final_ok && i_stat.has_payload) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_state = ST_STATUS;
                        end
                    end else begin
                        o_cmd.take_byte = 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_stat.last_read) begin
                        n_state = ST_COLLECT;
                    end
                end
            end
            ST_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.load_status = 1'b1;
                    n_state           = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

endmodule

// File: hw/rtl/scd_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// scd_datapath: deframer datapath
// Frame counters, running sum, signature check, payload memory and the
// output register.
// ============================================================================
module scd_datapath
    import scd_pkg::*;
#(
    parameter int SIG_LEN   = 2,
    parameter int MAX_FRAME = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIG_W-1:0]  i_signature,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  t_cmd              i_cmd,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_data_present,
    output logic              o_run_end,
    output logic              o_frame_status
);

    // Count of non-final words never exceeds MAX_FRAME-1.
    localparam int CNT_W = $clog2(MAX_FRAME);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_FRAME - 1);
    localparam logic [CNT_W-1:0] SIG_CNT  = CNT_W'(SIG_LEN);

    logic [BYTE_W-1:0] r_mem [MAX_FRAME];

    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_sig_ok, n_sig_ok;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_rd_ptr;
    logic              r_ok;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_present;
    logic              r_out_last;
    logic              r_out_status;

    logic              in_sig;
    logic [SIG_IDX_W-1:0] sig_idx;
    logic [BYTE_W-1:0] sig_byte;
    logic [CNT_W-1:0]  wr_ptr;
    logic              wr_en;
    logic [CNT_W-1:0]  final_len;

    assign in_sig    = int'(r_count) < SIG_LEN;
    assign sig_idx   = SIG_IDX_W'(r_count);
    assign sig_byte  = i_signature[BYTE_W*sig_idx +: BYTE_W];
    assign wr_ptr    = r_count - SIG_CNT;
    assign final_len = r_count - SIG_CNT;
    assign wr_en     = i_cmd.take_byte && !r_ovf && (r_count != LAST_CNT) && !in_sig;

    assign o_stat.final_ok    = !r_ovf && !in_sig && r_sig_ok && (i_rx_byte == r_sum);
    assign o_stat.has_payload = final_len != '0;
    assign o_stat.last_read   = r_rd_ptr == (r_len - CNT_W'(1));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_count  = r_count;
        n_sum    = r_sum;
        n_sig_ok = r_sig_ok;
        n_ovf    = r_ovf;
        if (i_cmd.take_final) begin
            n_count  = '0;
            n_sum    = '0;
            n_sig_ok = 1'b1;
            n_ovf    = 1'b0;
        end else if (i_cmd.take_byte && !r_ovf) begin
            if (r_count == LAST_CNT) begin
                n_ovf = 1'b1;
            end else begin
                if (in_sig && (i_rx_byte != sig_byte)) begin
                    n_sig_ok = 1'b0;
                end
                n_sum   = r_sum + i_rx_byte;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sig_ok    <= 1'b1;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
        end else begin
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_sig_ok <= n_sig_ok;
            r_ovf    <= n_ovf;
            if (i_cmd.take_final) begin
                r_rd_ptr <= '0;
            end else if (i_cmd.load_data) begin
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
            if (i_cmd.load_data || i_cmd.load_status) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload memory; its registered read port is the output data register.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_ptr] <= i_rx_byte;
        end
        if (i_cmd.load_data) begin
            r_out_data <= r_mem[r_rd_ptr];
        end else if (i_cmd.load_status) begin
            r_out_data <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_final) begin
            r_len <= final_len;
            r_ok  <= o_stat.final_ok;
        end
        if (i_cmd.load_data) begin
            r_out_present <= 1'b1;
            r_out_last    <= o_stat.last_read;
            r_out_status  <= 1'b0;
        end else if (i_cmd.load_status) begin
            r_out_present <= 1'b0;
            r_out_last    <= 1'b1;
            r_out_status  <= !r_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_data;
    assign o_data_present = r_out_present;
    assign o_run_end      = r_out_last;
    assign o_frame_status = r_out_status;

endmodule

// File: hw/rtl/signature_checksum_deframer.sv
`timescale 1ns / 1ps
// ============================================================================
// signature_checksum_deframer: frame sync word and additive checksum deframer
// Checks the leading signature bytes and the mod-256 checksum of each frame
// and releases the payload bytes of good frames.
// ============================================================================
//  channel  | direction | fields (lowest bit first)
//  s_axis   | in        | tdata: rx_byte; tlast: final_byte
//  m_axis   | out       | tdata: payload_byte; tuser: data_present, frame_status;
//           |           | tlast: run_end
//  apb      | in        | signature register at byte address 0, 64-bit data
//
// Non-final words and the final word are accepted while s_axis_tready is high.
// The frame then gives one result per cycle while m_axis does not stall, from the
// payload memory read port (or a single status result), and s_axis_tready stays low
// until the last result is loaded. A stall on m_axis holds the output register
// and the drain. Reset is synchronous and clears the frame state at once.
// ============================================================================
module signature_checksum_deframer
    import scd_pkg::*;
#(
    parameter int SIG_LEN   = 2,
    parameter int MAX_FRAME = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
    input  logic                  s_axis_tlast,   // final_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] payload_byte
    output logic [USER_W-1:0]     m_axis_tuser,   // [0] data_present, [1] frame_status
    output logic                  m_axis_tlast,   // run_end
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SIG_W-1:0] r_signature;
    logic             reg_sel;
    t_cmd             cmd;
    t_stat            stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3] == REG_SIGNATURE;
    assign prdata  = reg_sel ? r_signature : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signature <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_signature <= pwdata;
        end
    end

    scd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    scd_datapath #(
        .SIG_LEN   (SIG_LEN),
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_signature    (r_signature),
        .i_rx_byte      (s_axis_tdata),
        .i_cmd          (cmd),
        .i_out_ready    (m_axis_tready),
        .o_stat         (stat),
        .o_out_valid    (m_axis_tvalid),
        .o_payload_byte (m_axis_tdata),
        .o_data_present (m_axis_tuser[0]),
        .o_run_end      (m_axis_tlast),
        .o_frame_status (m_axis_tuser[1])
    );

endmodule

// File: tb/sv/signature_checksum_deframer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// signature_checksum_deframer_tb: self-checking testbench for the deframer
// Drives frames into the byte stream and checks every released word against
// a frame predictor. Frames are good, short, overlong, or carry a wrong
// signature or checksum. A short directed table comes first, then random
// frames under several signature settings, with random idling on both sides,
// a long receiver hold-off and a full drain before each register write.
// ============================================================================
module signature_checksum_deframer_tb;
    import scd_pkg::*;

    localparam int SIG_LEN     = 2;
    localparam int MAX_FRAME   = 64;
    localparam int CYCLE_LIMIT = 100000;

    // Signature register: index 0, registers 8 bytes apart.
    localparam logic [APB_ADDR_W-1:0] SIG_ADDR = {REG_SIGNATURE, 3'b000};

    localparam logic FRAME_OK  = 1'b0;
    localparam logic FRAME_BAD = 1'b1;
    localparam int   TU_PRESENT = 0;
    localparam int   TU_STATUS  = 1;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       status;
    } t_frame_res;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SIG,
        FR_BAD_SUM,
        FR_SHORT,
        FR_NOISE
    } t_frame_kind;

    // One directed word; where typed is set the word ends a frame whose single
    // status result is given here.
    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        logic       status;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // lone checksum word: too short
        '{8'h00, 1'b1, 1'b1, FRAME_BAD},
        // one signature word then checksum: too short
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h00, 1'b1, 1'b1, FRAME_BAD},
        // good frame with an empty payload
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h00, 1'b1, 1'b1, FRAME_OK},
        // first signature word wrong
        '{8'h01, 1'b0, 1'b0, FRAME_OK},
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h01, 1'b1, 1'b1, FRAME_BAD},
        // second signature word wrong, checksum right
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h80, 1'b0, 1'b0, FRAME_OK},
        '{8'h80, 1'b1, 1'b1, FRAME_BAD},
        // checksum wrong
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h05, 1'b0, 1'b0, FRAME_OK},
        '{8'h06, 1'b1, 1'b1, FRAME_BAD},
        // good frame with extreme payload bytes; the sum wraps
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'h00, 1'b0, 1'b0, FRAME_OK},
        '{8'hFF, 1'b0, 1'b0, FRAME_OK},
        '{8'h80, 1'b0, 1'b0, FRAME_OK},
        '{8'h7F, 1'b0, 1'b0, FRAME_OK},
        '{8'hFE, 1'b1, 1'b0, FRAME_OK}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] rx_byte
    logic                  s_axis_tlast;   // final_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;   // [7:0] payload_byte
    logic [USER_W-1:0]     m_axis_tuser;   // [0] data_present, [1] frame_status
    logic                  m_axis_tlast;   // run_end
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor copy of the register and the frame state.
    logic [63:0] exp_sig;
    logic [7:0]  frame_store [MAX_FRAME];
    int          frame_len;
    logic [7:0]  frame_sum;
    logic        sig_good;
    logic        frame_overrun;

    t_frame_res  expect_q [$];
    t_frame_res  want;
    int          err_cnt;
    int          words_sent;
    int          cycle_cnt;
    int          holdoff_left;
    bit          tx_gaps;
    bit          rx_free;

    signature_checksum_deframer #(
        .SIG_LEN   (SIG_LEN),
        .MAX_FRAME (MAX_FRAME)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_frame();
        frame_len     = 0;
        frame_sum     = 8'h00;
        sig_good      = 1'b1;
        frame_overrun = 1'b0;
    endfunction

    // Advances the frame state by one accepted word and queues the results
    // that the word releases.
    function automatic void decode_word(input logic [7:0] b, input logic fin);
        t_frame_res r;
        int         i;
        logic       ok;
        if (!fin) begin
            if (frame_overrun)
                return;
            if (frame_len + 1 >= MAX_FRAME) begin
                frame_overrun = 1'b1;
                return;
            end
            if (frame_len < SIG_LEN) begin
                if (b != exp_sig[8*frame_len +: 8])
                    sig_good = 1'b0;
            end else begin
                frame_store[frame_len - SIG_LEN] = b;
            end
            frame_sum = frame_sum + b;
            frame_len++;
            return;
        end
        ok = !frame_overrun && frame_len >= SIG_LEN && sig_good && b == frame_sum;
        if (ok && frame_len > SIG_LEN) begin
            for (i = 0; i < frame_len - SIG_LEN; i++) begin
                r = '{frame_store[i], 1'b1, (i == frame_len - SIG_LEN - 1), FRAME_OK};
                expect_q.push_back(r);
            end
        end else begin
            r = '{8'h00, 1'b0, 1'b1, ok ? FRAME_OK : FRAME_BAD};
            expect_q.push_back(r);
        end
        clear_frame();
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, exp_val);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expect_q.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 8'h00);
            end else begin
                want = expect_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("payload_byte", m_axis_tdata, want.data);
                if (m_axis_tuser[TU_PRESENT] !== want.present)
                    report_mismatch("data_present", 8'(m_axis_tuser[TU_PRESENT]),
                                    8'(want.present));
                if (m_axis_tlast !== want.last)
                    report_mismatch("run_end", 8'(m_axis_tlast), 8'(want.last));
                if (m_axis_tuser[TU_STATUS] !== want.status)
                    report_mismatch("frame_status", 8'(m_axis_tuser[TU_STATUS]),
                                    8'(want.status));
            end
        end
    end

    // Receiver: a requested hold-off is counted down here; otherwise it
    // stalls at random unless running free.
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_free) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // Offers one word and returns at the edge that takes it, leaving tvalid
    // high so that the next word can follow at once.
    task automatic send_word(input logic [7:0] b, input logic fin,
                             input bit typed = 1'b0, input logic status = FRAME_OK);
        int n0;
        if (tx_gaps) begin
            while ($urandom_range(0, 99) < 25) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        n0 = expect_q.size();
        decode_word(b, fin);
        if (typed) begin
            while (expect_q.size() > n0)
                void'(expect_q.pop_back());
            expect_q.push_back('{8'h00, 1'b0, 1'b1, status});
        end
    endtask

    task automatic stop_words();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expect_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_signature(input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIG_ADDR;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        exp_sig = v;
    endtask

    task automatic send_frame(input t_frame_kind kind, input int plen);
        logic [7:0] fb [$];
        logic [7:0] sum;
        int         i;
        int         cut;
        for (i = 0; i < SIG_LEN; i++)
            fb.push_back(exp_sig[8*i +: 8]);
        if (kind == FR_BAD_SIG) begin
            i = $urandom_range(0, SIG_LEN - 1);
            fb[i] = fb[i] ^ 8'($urandom_range(1, 255));
        end
        for (i = 0; i < plen; i++)
            fb.push_back(8'($urandom));
        if (kind == FR_NOISE) begin
            foreach (fb[j])
                fb[j] = 8'($urandom);
        end
        if (kind == FR_SHORT) begin
            cut = $urandom_range(0, SIG_LEN - 1);
            while (fb.size() > cut)
                void'(fb.pop_back());
        end
        sum = 8'h00;
        foreach (fb[j])
            sum = sum + fb[j];
        if (kind == FR_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        if (kind == FR_NOISE || kind == FR_SHORT)
            sum = 8'($urandom);
        foreach (fb[j])
            send_word(fb[j], 1'b0);
        send_word(sum, 1'b1);
    endtask

    // Mostly well-formed frames with short payloads; now and then a longer one.
    task automatic run_frames(input int n_words);
        t_frame_kind kind;
        int          pick;
        int          plen;
        int          start;
        start = words_sent;
        while (words_sent - start < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                kind = FR_GOOD;
            else if (pick < 78)
                kind = FR_BAD_SIG;
            else if (pick < 86)
                kind = FR_BAD_SUM;
            else if (pick < 93)
                kind = FR_SHORT;
            else
                kind = FR_NOISE;
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            send_frame(kind, plen);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_cnt       = 0;
        words_sent    = 0;
        cycle_cnt     = 0;
        holdoff_left  = 0;
        tx_gaps       = 1'b1;
        rx_free       = 1'b0;
        exp_sig       = '0;
        clear_frame();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_signature(64'h0);
        for (int r = 0; r < DIR_ROWS; r++)
            send_word(DIR_TAB[r].b, DIR_TAB[r].fin, DIR_TAB[r].typed, DIR_TAB[r].status);
        stop_words();
        wait_idle();

        // All-ones signature with no idling on either side; includes the
        // longest frame that passes and one that runs past the buffer.
        write_signature(64'hFFFF_FFFF_FFFF_FFFF);
        tx_gaps = 1'b0;
        rx_free = 1'b1;
        send_frame(FR_GOOD, MAX_FRAME - SIG_LEN - 1);
        send_frame(FR_GOOD, MAX_FRAME - SIG_LEN + 1);
        run_frames(6);
        tx_gaps = 1'b1;
        rx_free = 1'b0;

        // The receiver holds off while frames keep coming, so the block backs
        // up and stalls its input; then the sender waits for a full drain.
        holdoff_left = 300;
        send_frame(FR_GOOD, 8);
        send_frame(FR_BAD_SUM, 3);
        send_frame(FR_GOOD, 0);
        stop_words();
        wait_idle();

        write_signature({$urandom, $urandom});
        run_frames(8);
        stop_words();
        wait_idle();

        write_signature({$urandom, $urandom});
        run_frames(8);
        stop_words();
        wait_idle();
        repeat (16) @(posedge i_clk);

        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
